// File: src/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// File: src/all_pkg.sv
// ----------------------------------------------------------------------------
// all_pkg: shared types and constants of the line lexer
// Lexer modes, token and error codes, result word layout.
// ----------------------------------------------------------------------------
package all_pkg;
  localparam int POS_BITS = 8;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [3:0] M_LEAD = 4'd0;
  localparam logic [3:0] M_GAP = 4'd1;
  localparam logic [3:0] M_STR = 4'd2;
  localparam logic [3:0] M_SYM = 4'd3;
  localparam logic [3:0] M_INSTR = 4'd4;
  localparam logic [3:0] M_NUM = 4'd5;
  localparam logic [3:0] M_DOLLAR = 4'd6;
  localparam logic [3:0] M_CHAR = 4'd7;
  localparam logic [3:0] M_DOT = 4'd8;
  localparam logic [3:0] M_QUEST = 4'd9;

  localparam logic [1:0] K_TOKEN = 2'd0;
  localparam logic [1:0] K_ERROR = 2'd1;
  localparam logic [1:0] K_EOL = 2'd2;

  localparam logic [4:0] TOK_STR = 5'd1;
  localparam logic [4:0] TOK_CONST = 5'd2;
  localparam logic [4:0] TOK_LONE_SIGIL = 5'd3;
  localparam logic [4:0] TOK_NUM = 5'd4;
  localparam logic [4:0] TOK_KEY_BASE = 5'd11;
  localparam logic [4:0] TOK_LABEL = 5'd19;
  localparam logic [4:0] TOK_COND = 5'd22;
  localparam logic [4:0] TOK_LOCAL = 5'd27;
  localparam logic [4:0] TOK_INSTR = 5'd29;

  localparam logic [3:0] E_DIGIT = 4'd0;
  localparam logic [3:0] E_BIG = 4'd1;
  localparam logic [3:0] E_CHAR = 4'd2;
  localparam logic [3:0] E_INSTR = 4'd3;
  localparam logic [3:0] E_SYMBOL = 4'd4;
  localparam logic [3:0] E_STRING = 4'd5;
  localparam logic [3:0] E_KEYWORD = 4'd6;
  localparam logic [3:0] E_COND = 4'd7;
  localparam logic [3:0] E_LONG = 4'd8;

  localparam logic [1:0] CFG_MAX_NUMBER = 2'd0;
  localparam logic [1:0] CFG_MAX_SYMBOL = 2'd1;
  localparam logic [1:0] CFG_MAX_LINE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  token_type;
    logic [3:0]  error_code;
    logic [7:0]  column;
    logic [7:0]  length;
    logic [7:0]  text_start;
    logic [31:0] value;
  } res_t;

  // Up to three results per character.
  typedef struct packed {
    logic [1:0] cnt;
    res_t [2:0] r;
  } bundle_t;

  typedef struct packed {
    logic [31:0] max_number;
    logic [5:0]  max_symbol_len;
    logic [7:0]  max_line_len;
  } cfg_t;

  function automatic logic [7:0] sat8(input logic [POS_BITS:0] x);
    if (x > (POS_BITS+1)'(255)) return 8'd255;
    return x[7:0];
  endfunction
endpackage

// File: src/all_core.sv
// ----------------------------------------------------------------------------
// all_core: lexer state and per-character decode
// Updates lexer state on each accepted character and produces a result bundle.
// ----------------------------------------------------------------------------
module all_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          ch,
  input  all_pkg::cfg_t       cfg,
  output all_pkg::bundle_t    bnd
);
  localparam int PB = all_pkg::POS_BITS;

  logic [3:0]    mode_r, mode_nxt;
  logic [4:0]    cls_r, cls_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [PB-1:0] beg_r, beg_nxt;
  logic [32:0]   acc_r, acc_nxt;
  logic          bad_r, bad_nxt;
  logic          disc_r, disc_nxt;

  // Combinational decode of one character.
  always_comb begin
    logic          sp, pr, eol, emitted, chk, fin_ok;
    logic [PB-1:0] p, b;
    logic [4:0]    d;
    logic          dv;
    logic [36:0]   prod;
    logic [36:0]   sum;
    logic [PB-1:0] len;
    all_pkg::res_t t;
    mode_nxt = mode_r; cls_nxt = cls_r; pos_nxt = pos_r; beg_nxt = beg_r;
    acc_nxt = acc_r; bad_nxt = bad_r; disc_nxt = disc_r;
    bnd = '0;
    p = pos_r; b = beg_r;
    sp = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    pr = (ch >= 8'd32) && (ch <= 8'd126);
    eol = (ch == 8'd0) || (ch == 8'd10);
    emitted = 1'b0; chk = 1'b0; fin_ok = 1'b0;
    d = 5'd31; dv = 1'b0; prod = '0; sum = '0; t = '0;
    len = p - b;

    // digit in current base
    if (ch >= "0" && ch <= "9") d = 5'(ch - "0");
    else if (ch >= "a" && ch <= "f") d = 5'(ch - "a" + 8'd10);
    else if (ch >= "A" && ch <= "F") d = 5'(ch - "A" + 8'd10);
    if (mode_r == all_pkg::M_DOLLAR) dv = (d < 5'd16);
    else dv = (d < cls_r);

    // base-times-accumulator as shifts and adds, wide enough to see overflow
    case (cls_r)
      5'd2:    prod = {4'b0, acc_r[31:0], 1'b0};
      5'd16:   prod = {1'b0, acc_r[31:0], 4'b0};
      default: prod = {2'b0, acc_r[31:0], 3'b0} + {4'b0, acc_r[31:0], 1'b0};
    endcase
    sum = prod + 37'(d);

    if (eol) begin
      if (!disc_r) begin
        case (mode_r)
          all_pkg::M_GAP: chk = 1'b1;
          all_pkg::M_SYM, all_pkg::M_INSTR, all_pkg::M_NUM: fin_ok = 1'b1;
          all_pkg::M_DOLLAR: begin
            t = '{all_pkg::K_TOKEN, all_pkg::TOK_NUM, 4'd0,
                  all_pkg::sat8({1'b0, b} + 1'b1), 8'd1, all_pkg::sat8({1'b0, b}), 32'd0};
            emitted = 1'b1; chk = 1'b1;
          end
          all_pkg::M_STR: begin
            t = '{all_pkg::K_ERROR, 5'd0, all_pkg::E_STRING,
                  all_pkg::sat8({1'b0, b} + 1'b1), all_pkg::sat8({1'b0, len}),
                  all_pkg::sat8({1'b0, b}), 32'd0};
            emitted = 1'b1;
          end
          all_pkg::M_CHAR, all_pkg::M_DOT, all_pkg::M_QUEST: begin
            t = '{all_pkg::K_ERROR, 5'd0,
                  (mode_r == all_pkg::M_CHAR) ? all_pkg::E_CHAR :
                  (mode_r == all_pkg::M_DOT) ? all_pkg::E_KEYWORD : all_pkg::E_COND,
                  all_pkg::sat8({1'b0, b} + 1'b1), 8'd2, all_pkg::sat8({1'b0, b}), 32'd0};
            emitted = 1'b1;
          end
          default: ;
        endcase
      end
      mode_nxt = all_pkg::M_LEAD; pos_nxt = '0; beg_nxt = '0; disc_nxt = 1'b0;
    end else begin
      pos_nxt = (p < all_pkg::POS_MAX) ? p + 1'b1 : all_pkg::POS_MAX;
      if (!disc_r) begin
        case (mode_r)
          all_pkg::M_LEAD, all_pkg::M_GAP: begin
            if (!sp) begin
              if (mode_r == all_pkg::M_GAP && {1'b0, p} > (PB+1)'(cfg.max_line_len)) begin
                t = '{all_pkg::K_ERROR, 5'd0, all_pkg::E_LONG,
                      all_pkg::sat8({1'b0, p} + 1'b1), 8'd0, all_pkg::sat8({1'b0, p}), 32'd0};
                emitted = 1'b1; beg_nxt = p;
                disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
              end else begin
                beg_nxt = p;
                t = '{all_pkg::K_TOKEN, 5'd0, 4'd0, all_pkg::sat8({1'b0, p} + 1'b1), 8'd1,
                      all_pkg::sat8({1'b0, p}), 32'd0};
                mode_nxt = all_pkg::M_GAP;
                case (ch)
                  "!": emitted = 1'b1;
                  "&": begin t.token_type = 5'd5; emitted = 1'b1; end
                  "(": begin t.token_type = 5'd6; emitted = 1'b1; end
                  ")": begin t.token_type = 5'd7; emitted = 1'b1; end
                  "*": begin t.token_type = 5'd8; emitted = 1'b1; end
                  "+": begin t.token_type = 5'd9; emitted = 1'b1; end
                  "-": begin t.token_type = 5'd10; emitted = 1'b1; end
                  "/": begin t.token_type = 5'd18; emitted = 1'b1; end
                  "<": begin t.token_type = 5'd20; emitted = 1'b1; end
                  ">": begin t.token_type = 5'd21; emitted = 1'b1; end
                  "[": begin t.token_type = 5'd23; emitted = 1'b1; end
                  "\\": begin t.token_type = 5'd24; emitted = 1'b1; end
                  "]": begin t.token_type = 5'd25; emitted = 1'b1; end
                  "^": begin t.token_type = 5'd26; emitted = 1'b1; end
                  "|": begin t.token_type = 5'd28; emitted = 1'b1; end
                  "\"": mode_nxt = all_pkg::M_STR;
                  "#": begin mode_nxt = all_pkg::M_SYM; cls_nxt = all_pkg::TOK_CONST; end
                  ":": begin mode_nxt = all_pkg::M_SYM; cls_nxt = all_pkg::TOK_LABEL; end
                  "_": begin mode_nxt = all_pkg::M_SYM; cls_nxt = all_pkg::TOK_LOCAL; end
                  "$": mode_nxt = all_pkg::M_DOLLAR;
                  "%": begin
                    mode_nxt = all_pkg::M_NUM; cls_nxt = 5'd2; acc_nxt = '0; bad_nxt = 1'b0;
                  end
                  "'": mode_nxt = all_pkg::M_CHAR;
                  ".": mode_nxt = all_pkg::M_DOT;
                  "?": mode_nxt = all_pkg::M_QUEST;
                  ";": begin disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD; end
                  default: begin
                    if (ch >= "0" && ch <= "9") begin
                      mode_nxt = all_pkg::M_NUM; cls_nxt = 5'd10;
                      acc_nxt = 33'(ch - "0"); bad_nxt = 1'b0;
                    end else begin
                      mode_nxt = all_pkg::M_INSTR;
                    end
                  end
                endcase
              end
            end
          end
          all_pkg::M_SYM: if (sp) fin_ok = 1'b1;
          all_pkg::M_INSTR: begin
            if (sp) fin_ok = 1'b1;
            else if (!pr) begin
              t = '{all_pkg::K_ERROR, 5'd0, all_pkg::E_INSTR,
                    all_pkg::sat8({1'b0, b} + 1'b1), all_pkg::sat8({1'b0, len}),
                    all_pkg::sat8({1'b0, b}), 32'd0};
              emitted = 1'b1; disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
            end
          end
          all_pkg::M_NUM, all_pkg::M_DOLLAR: begin
            if (sp) begin
              if (mode_r == all_pkg::M_DOLLAR) begin
                t = '{all_pkg::K_TOKEN, all_pkg::TOK_LONE_SIGIL, 4'd0,
                      all_pkg::sat8({1'b0, b} + 1'b1), 8'd1, all_pkg::sat8({1'b0, b}), 32'd0};
                emitted = 1'b1; mode_nxt = all_pkg::M_GAP;
              end else fin_ok = 1'b1;
            end else if (!dv) begin
              t = '{all_pkg::K_ERROR, 5'd0, all_pkg::E_DIGIT,
                    all_pkg::sat8({1'b0, b} + 1'b1), 8'd1, all_pkg::sat8({1'b0, p}), 32'd0};
              emitted = 1'b1; disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
              if (mode_r == all_pkg::M_DOLLAR) cls_nxt = 5'd16;
            end else begin
              mode_nxt = all_pkg::M_NUM;
              if (mode_r == all_pkg::M_DOLLAR) begin
                cls_nxt = 5'd16; acc_nxt = 33'(d); bad_nxt = 1'b0;
              end else begin
                acc_nxt = sum[32:0];
                if (sum[36:32] != 5'd0) begin
                  bad_nxt = 1'b1; acc_nxt = 33'h0_FFFF_FFFF;
                end
              end
            end
          end
          all_pkg::M_STR: begin
            if (ch == "\"") begin
              t = '{all_pkg::K_TOKEN, all_pkg::TOK_STR, 4'd0,
                    all_pkg::sat8({1'b0, b} + 1'b1),
                    all_pkg::sat8({1'b0, (len != '0) ? len - 1'b1 : len}),
                    all_pkg::sat8({1'b0, b} + 1'b1), 32'd0};
              emitted = 1'b1; mode_nxt = all_pkg::M_GAP;
            end else if (!pr) begin
              t = '{all_pkg::K_ERROR, 5'd0, all_pkg::E_STRING,
                    all_pkg::sat8({1'b0, b} + 1'b1), all_pkg::sat8({1'b0, len}),
                    all_pkg::sat8({1'b0, b}), 32'd0};
              emitted = 1'b1; disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
            end
          end
          all_pkg::M_CHAR: begin
            emitted = 1'b1;
            if (!pr || sp) begin
              t = '{all_pkg::K_ERROR, 5'd0, all_pkg::E_CHAR,
                    all_pkg::sat8({1'b0, b} + 1'b1), 8'd2, all_pkg::sat8({1'b0, b}), 32'd0};
              disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
            end else begin
              t = '{all_pkg::K_TOKEN, all_pkg::TOK_NUM, 4'd0,
                    all_pkg::sat8({1'b0, b} + 1'b1), 8'd2, all_pkg::sat8({1'b0, b}),
                    32'(ch)};
              mode_nxt = all_pkg::M_GAP;
            end
          end
          all_pkg::M_DOT: begin
            emitted = 1'b1;
            t = '{all_pkg::K_TOKEN, 5'd0, 4'd0,
                  all_pkg::sat8({1'b0, b} + 1'b1), 8'd2, all_pkg::sat8({1'b0, b}), 32'd0};
            mode_nxt = all_pkg::M_GAP;
            case (ch)
              "a": t.token_type = all_pkg::TOK_KEY_BASE;
              "b": t.token_type = all_pkg::TOK_KEY_BASE + 5'd1;
              "f": t.token_type = all_pkg::TOK_KEY_BASE + 5'd2;
              "i": t.token_type = all_pkg::TOK_KEY_BASE + 5'd3;
              "m": t.token_type = all_pkg::TOK_KEY_BASE + 5'd4;
              "r": t.token_type = all_pkg::TOK_KEY_BASE + 5'd5;
              "w": t.token_type = all_pkg::TOK_KEY_BASE + 5'd6;
              default: begin
                t.kind = all_pkg::K_ERROR; t.error_code = all_pkg::E_KEYWORD;
                disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
              end
            endcase
          end
          default: begin
            emitted = 1'b1;
            if (ch == "=" || ch == "-" || ch == "!" || ch == "+") begin
              t = '{all_pkg::K_TOKEN, all_pkg::TOK_COND, 4'd0,
                    all_pkg::sat8({1'b0, b} + 1'b1), 8'd2, all_pkg::sat8({1'b0, b}),
                    32'(ch)};
              mode_nxt = all_pkg::M_GAP;
            end else begin
              t = '{all_pkg::K_ERROR, 5'd0, all_pkg::E_COND,
                    all_pkg::sat8({1'b0, b} + 1'b1), 8'd2, all_pkg::sat8({1'b0, b}), 32'd0};
              disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
            end
          end
        endcase
      end
    end

    // close a symbol, instruction or number
    if (fin_ok) begin
      emitted = 1'b1; mode_nxt = all_pkg::M_GAP; chk = eol;
      t = '{all_pkg::K_TOKEN, all_pkg::TOK_INSTR, 4'd0, all_pkg::sat8({1'b0, b} + 1'b1),
            all_pkg::sat8({1'b0, len}), all_pkg::sat8({1'b0, b}), 32'd0};
      if (mode_r == all_pkg::M_SYM) begin
        t.token_type = cls_r;
        if ({1'b0, len} > (PB+1)'(cfg.max_symbol_len)) begin
          t.kind = all_pkg::K_ERROR; t.token_type = 5'd0; t.error_code = all_pkg::E_SYMBOL;
          chk = 1'b0; disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
        end
      end else if (mode_r == all_pkg::M_NUM) begin
        t.token_type = all_pkg::TOK_NUM; t.value = acc_r[31:0];
        if (bad_r || acc_r > {1'b0, cfg.max_number}) begin
          t.kind = all_pkg::K_ERROR; t.token_type = 5'd0; t.error_code = all_pkg::E_BIG;
          t.value = '0; chk = 1'b0; disc_nxt = 1'b1; mode_nxt = all_pkg::M_LEAD;
        end
      end
      // a line end always returns to line start
      if (eol) begin
        mode_nxt = all_pkg::M_LEAD; disc_nxt = 1'b0;
      end
    end

    // assemble the bundle
    if (emitted) begin bnd.r[0] = t; bnd.cnt = 2'd1; end
    if (eol) begin
      if (chk && {1'b0, p} > (PB+1)'(cfg.max_line_len)) begin
        bnd.r[bnd.cnt] = '{all_pkg::K_ERROR, 5'd0, all_pkg::E_LONG,
                           all_pkg::sat8({1'b0, p} + 1'b1), 8'd0,
                           all_pkg::sat8({1'b0, p}), 32'd0};
        bnd.cnt = bnd.cnt + 2'd1;
      end
      bnd.r[bnd.cnt] = '{all_pkg::K_EOL, 5'd0, 4'd0, 8'd0, all_pkg::sat8({1'b0, p}),
                         8'd0, 32'd0};
      bnd.cnt = bnd.cnt + 2'd1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= all_pkg::M_LEAD; cls_r <= '0; pos_r <= '0; beg_r <= '0;
      acc_r <= '0; bad_r <= 1'b0; disc_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt; cls_r <= cls_nxt; pos_r <= pos_nxt; beg_r <= beg_nxt;
      acc_r <= acc_nxt; bad_r <= bad_nxt; disc_r <= disc_nxt;
    end
  end
endmodule

// File: src/all_outq.sv
// ----------------------------------------------------------------------------
// all_outq: result word queue
// Holds up to two bundles; one result word leaves per ready cycle.
// ----------------------------------------------------------------------------
module all_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  all_pkg::bundle_t  bnd,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output all_pkg::res_t     res,
  output logic              last
);
  all_pkg::bundle_t [1:0] slot_r;
  logic [1:0] occ_r, occ_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       pop, done;

  assign out_valid = occ_r != 2'd0;
  assign res = slot_r[rd_r].r[idx_r];
  assign last = (idx_r + 2'd1) == slot_r[rd_r].cnt;
  assign pop = out_valid && out_ready;
  assign done = pop && last;
  assign can_push = (occ_r != 2'd2) || done;

  // occupancy and pointers
  always_comb begin
    logic in;
    in = push && (bnd.cnt != 2'd0);
    occ_nxt = occ_r + {1'b0, in} - {1'b0, done};
    rd_nxt = done ? ~rd_r : rd_r;
    wr_nxt = in ? ~wr_r : wr_r;
    idx_nxt = done ? 2'd0 : (pop ? idx_r + 2'd1 : idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; idx_r <= '0;
    end else begin
      occ_r <= occ_nxt; rd_r <= rd_nxt; wr_r <= wr_nxt; idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && bnd.cnt != 2'd0) slot_r[wr_r] <= bnd;
  end
endmodule

// File: src/assembler_line_lexer_unit.sv
// With an empty queue a character's first result is offered in the cycle after
// acceptance.
// Throughput: one character per cycle while each yields at most one result word;
// one word leaves per ready cycle, and the full two-bundle queue stalls input.
// Reset (rst_n low, synchronous) returns the lexer to line start, empties the
// result queue and restores default register values.
// ----------------------------------------------------------------------------
// assembler_line_lexer_unit: assembler line lexer top level
// Character decode into a two-bundle result queue, plus configuration regs.
// ----------------------------------------------------------------------------
module assembler_line_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [4:0]  out_token_type,
  output logic [3:0]  out_error_code,
  output logic [7:0]  out_column,
  output logic [7:0]  out_length,
  output logic [7:0]  out_text_start,
  output logic [31:0] out_value,
  output logic        out_last_of_run
);
  all_pkg::cfg_t    cfg_r;
  all_pkg::bundle_t bnd;
  all_pkg::res_t    res;
  logic             step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{32'd65535, 6'd31, 8'd127};
    end else if (cfg_we) begin
      case (cfg_index)
        all_pkg::CFG_MAX_NUMBER: cfg_r.max_number <= cfg_data;
        all_pkg::CFG_MAX_SYMBOL: cfg_r.max_symbol_len <= cfg_data[5:0];
        all_pkg::CFG_MAX_LINE:   cfg_r.max_line_len <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign step = in_valid && in_ready;

  all_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .ch(in_ch), .cfg(cfg_r), .bnd(bnd)
  );

  all_outq u_outq (
    .clk(clk), .rst_n(rst_n), .push(step), .bnd(bnd), .can_push(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .res(res), .last(out_last_of_run)
  );

  assign out_kind = res.kind;
  assign out_token_type = res.token_type;
  assign out_error_code = res.error_code;
  assign out_column = res.column;
  assign out_length = res.length;
  assign out_text_start = res.text_start;
  assign out_value = res.value;
endmodule

// File: src/all_checker.sv
// ----------------------------------------------------------------------------
// all_checker: port-level checks of the line lexer
// Watches result words and the handshake on the top level ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module all_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [4:0]  out_token_type,
  input logic [3:0]  out_error_code,
  input logic [7:0]  out_column,
  input logic [7:0]  out_length,
  input logic        out_last_of_run
);
  logic eol_w, err_w, tok_w;

  // word kind on a valid result
  assign eol_w = out_valid && out_kind == all_pkg::K_EOL;
  assign err_w = out_valid && out_kind == all_pkg::K_ERROR;
  assign tok_w = out_valid && out_kind == all_pkg::K_TOKEN;

  `CHK_IMPLY(a_eol_last, clk, rst_n, eol_w, out_last_of_run && out_column == 8'd0)
  `CHK_IMPLY(a_err_type, clk, rst_n, err_w, out_token_type == 5'd0)
  `CHK_IMPLY(a_tok_err, clk, rst_n, tok_w, out_error_code == 4'd0 && out_column != 8'd0)
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_length))
endmodule

bind assembler_line_lexer_unit all_checker u_all_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_kind(out_kind), .out_token_type(out_token_type), .out_error_code(out_error_code),
  .out_column(out_column), .out_length(out_length), .out_last_of_run(out_last_of_run)
);
